>>> rtl/qat_pkg.sv
`timescale 1ns / 1ps
// Shared widths, types and constants for the quaternion box transform.
package qat_pkg;

    localparam int NSTAGE   = 6;
    localparam int AXES     = 3;
    localparam int MAT_N    = AXES * AXES;

    localparam int QUAT_W   = 64;
    localparam int LANE_W   = 16;
    localparam int QPROD_W  = 2 * LANE_W;
    localparam int CW       = 32;
    localparam int MAT_FRAC = 28;

    // off-diagonal entries reach +2^32 when every lane is -2.0
    localparam int MW       = 34;
    localparam int ML       = 17;
    localparam int MH       = MW - ML;
    localparam int PLW      = ML + 1 + CW;
    localparam int PHW      = MH + CW;
    localparam int PW       = MW + CW;
    localparam int TW       = PW - MAT_FRAC;
    localparam int SW       = TW + 2;

    localparam int IN_W     = QUAT_W + 9 * CW;
    localparam int OUT_W    = 6 * CW;

    typedef logic signed [LANE_W-1:0]  t_lane;
    typedef logic signed [QPROD_W-1:0] t_qprod;
    typedef logic signed [MW:0]        t_mwide;
    typedef logic signed [MW-1:0]      t_mat;
    typedef logic signed [CW-1:0]      t_coord;
    typedef logic signed [PW-1:0]      t_prod;
    typedef logic signed [TW-1:0]      t_term;
    typedef logic signed [SW-1:0]      t_sum;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } t_pipe_en;

    localparam t_mwide MAT_ONE    = t_mwide'(1) <<< MAT_FRAC;
    localparam t_prod  ROUND_HALF = t_prod'(1) <<< (MAT_FRAC - 1);
    localparam t_sum   SUM_MAX    = (t_sum'(1) <<< (CW - 1)) - t_sum'(1);
    localparam t_sum   SUM_MIN    = -(t_sum'(1) <<< (CW - 1));

endpackage

>>> rtl/qat_matrix.sv
`timescale 1ns / 1ps
// Quaternion lane products and rotation matrix entries, two pipeline stages.
module qat_matrix import qat_pkg::*; (
    input  logic              i_clk,
    input  t_pipe_en          i_en,
    input  logic [QUAT_W-1:0] i_quat,
    output t_mat              o_m [MAT_N]
);

    t_lane  q_x, q_y, q_z, q_w;
    t_qprod r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    t_mwide w_xx, w_yy, w_zz, w_xy, w_xz, w_yz, w_wx, w_wy, w_wz;
    t_mwide d [MAT_N];
    t_mat   r_m [MAT_N];

    assign q_x = i_quat[LANE_W-1:0];
    assign q_y = i_quat[2*LANE_W-1:LANE_W];
    assign q_z = i_quat[3*LANE_W-1:2*LANE_W];
    assign q_w = i_quat[4*LANE_W-1:3*LANE_W];

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_xx <= q_x * q_x;
            r_yy <= q_y * q_y;
            r_zz <= q_z * q_z;
            r_xy <= q_x * q_y;
            r_xz <= q_x * q_z;
            r_yz <= q_y * q_z;
            r_wx <= q_w * q_x;
            r_wy <= q_w * q_y;
            r_wz <= q_w * q_z;
        end
    end

    assign w_xx = t_mwide'(r_xx);
    assign w_yy = t_mwide'(r_yy);
    assign w_zz = t_mwide'(r_zz);
    assign w_xy = t_mwide'(r_xy);
    assign w_xz = t_mwide'(r_xz);
    assign w_yz = t_mwide'(r_yz);
    assign w_wx = t_mwide'(r_wx);
    assign w_wy = t_mwide'(r_wy);
    assign w_wz = t_mwide'(r_wz);

    assign d[0] = MAT_ONE - ((w_yy + w_zz) <<< 1);
    assign d[1] = (w_xy - w_wz) <<< 1;
    assign d[2] = (w_xz + w_wy) <<< 1;
    assign d[3] = (w_xy + w_wz) <<< 1;
    assign d[4] = MAT_ONE - ((w_xx + w_zz) <<< 1);
    assign d[5] = (w_yz - w_wx) <<< 1;
    assign d[6] = (w_xz - w_wy) <<< 1;
    assign d[7] = (w_yz + w_wx) <<< 1;
    assign d[8] = MAT_ONE - ((w_xx + w_yy) <<< 1);

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            for (int i = 0; i < MAT_N; i++) begin
                r_m[i] <= d[i][MW-1:0];
            end
        end
    end

    assign o_m = r_m;

endmodule

>>> rtl/qat_term.sv
`timescale 1ns / 1ps
// Matrix entry times coordinate: split partial products, then sum and round.
module qat_term import qat_pkg::*; (
    input  logic     i_clk,
    input  t_pipe_en i_en,
    input  t_mat     i_m,
    input  t_coord   i_c,
    output t_term    o_term
);

    logic [ML-1:0]          m_lo;
    logic signed [MH-1:0]   m_hi;
    logic signed [PLW-1:0]  n_plo, r_plo;
    logic signed [PHW-1:0]  n_phi, r_phi;
    t_prod                  p_full;
    t_term                  r_term;

    assign m_lo  = i_m[ML-1:0];
    assign m_hi  = i_m[MW-1:ML];
    assign n_plo = $signed({1'b0, m_lo}) * i_c;
    assign n_phi = m_hi * i_c;

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_plo <= n_plo;
            r_phi <= n_phi;
        end
    end

    // round half up, arithmetic shift by the matrix fraction
    assign p_full = (t_prod'(r_phi) <<< ML) + t_prod'(r_plo) + ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_term <= p_full[PW-1:MAT_FRAC];
        end
    end

    assign o_term = r_term;

endmodule

>>> rtl/qat_bound.sv
`timescale 1ns / 1ps
// One world axis: order the term pairs, sum with the position, saturate.
module qat_bound import qat_pkg::*; (
    input  logic     i_clk,
    input  t_pipe_en i_en,
    input  t_coord   i_pos,
    input  t_term    i_a [AXES],
    input  t_term    i_b [AXES],
    output t_coord   o_min,
    output t_coord   o_max,
    output logic     o_ovf
);

    t_term  r_lo [AXES];
    t_term  r_hi [AXES];
    t_coord r_pos;
    t_sum   s_lo, s_hi;
    t_coord n_min, n_max, r_min, r_max;
    logic   n_ovf, r_ovf;

    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            for (int k = 0; k < AXES; k++) begin
                if (i_a[k] < i_b[k]) begin
                    r_lo[k] <= i_a[k];
                    r_hi[k] <= i_b[k];
                end else begin
                    r_lo[k] <= i_b[k];
                    r_hi[k] <= i_a[k];
                end
            end
            r_pos <= i_pos;
        end
    end

    assign s_lo = t_sum'(r_pos) + t_sum'(r_lo[0]) + t_sum'(r_lo[1]) + t_sum'(r_lo[2]);
    assign s_hi = t_sum'(r_pos) + t_sum'(r_hi[0]) + t_sum'(r_hi[1]) + t_sum'(r_hi[2]);

    always_comb begin
        n_ovf = 1'b0;
        n_min = s_lo[CW-1:0];
        n_max = s_hi[CW-1:0];
        if (s_lo > SUM_MAX) begin
            n_min = SUM_MAX[CW-1:0];
            n_ovf = 1'b1;
        end else if (s_lo < SUM_MIN) begin
            n_min = SUM_MIN[CW-1:0];
            n_ovf = 1'b1;
        end
        if (s_hi > SUM_MAX) begin
            n_max = SUM_MAX[CW-1:0];
            n_ovf = 1'b1;
        end else if (s_hi < SUM_MIN) begin
            n_max = SUM_MIN[CW-1:0];
            n_ovf = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s6) begin
            r_min <= n_min;
            r_max <= n_max;
            r_ovf <= n_ovf;
        end
    end

    assign o_min = r_min;
    assign o_max = r_max;
    assign o_ovf = r_ovf;

endmodule

>>> rtl/quaternion_aabb_transform_unit.sv
`timescale 1ns / 1ps
// Transformed bounding box of a quaternion-rotated object (Arvo's method).
//
// Takes one object per beat and returns its world-space box one beat per input, in order.
// Each accepted input beat flows through every stage to the output beat; one object can
// enter every cycle while the output is not stalled. The rate is set by the six-stage
// pipeline: lane products, matrix entries, eighteen split 34x32 multiplies (two partial
// products each), rounding, min/max ordering, and the four-term sum with saturation. Each
// stage advances when it is empty or the stage after it advances, so bubbles are squeezed
// out and a stalled output holds the pipeline without loss. The tuser bit flags a saturated bound.
module quaternion_aabb_transform_unit import qat_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    // quat_packed, local_min_x/y/z, local_max_x/y/z, pos_x/y/z
    input  logic [IN_W-1:0]  i_s_tdata,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // world_min_x/y/z, world_max_x/y/z
    output logic [OUT_W-1:0] o_m_tdata,
    // overflow
    output logic             o_m_tuser
);

    logic [NSTAGE-1:0] r_v, n_v, w_en_v;
    t_pipe_en          w_en;

    t_coord in_min [AXES];
    t_coord in_max [AXES];
    t_coord in_pos [AXES];
    t_coord r_min1 [AXES];
    t_coord r_max1 [AXES];
    t_coord r_min2 [AXES];
    t_coord r_max2 [AXES];
    t_coord r_pos1 [AXES];
    t_coord r_pos2 [AXES];
    t_coord r_pos3 [AXES];
    t_coord r_pos4 [AXES];

    t_mat   w_m [MAT_N];
    t_term  w_ta [AXES][AXES];
    t_term  w_tb [AXES][AXES];
    t_coord w_wmin [AXES];
    t_coord w_wmax [AXES];
    logic [AXES-1:0] w_ovf;

    always_comb begin
        w_en_v[NSTAGE-1] = !r_v[NSTAGE-1] || i_m_tready;
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            w_en_v[i] = !r_v[i] || w_en_v[i+1];
        end
        n_v[0] = w_en_v[0] ? i_s_tvalid : r_v[0];
        for (int i = 1; i < NSTAGE; i++) begin
            if (w_en_v[i]) begin
                n_v[i] = r_v[i-1];
            end else begin
                n_v[i] = r_v[i];
            end
        end
    end

    assign w_en.s1 = w_en_v[0];
    assign w_en.s2 = w_en_v[1];
    assign w_en.s3 = w_en_v[2];
    assign w_en.s4 = w_en_v[3];
    assign w_en.s5 = w_en_v[4];
    assign w_en.s6 = w_en_v[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_s_tready = w_en_v[0];
    assign o_m_tvalid = r_v[NSTAGE-1];

    for (genvar k = 0; k < AXES; k++) begin : g_unpack
        assign in_min[k] = i_s_tdata[QUAT_W + k*CW +: CW];
        assign in_max[k] = i_s_tdata[QUAT_W + (AXES+k)*CW +: CW];
        assign in_pos[k] = i_s_tdata[QUAT_W + (2*AXES+k)*CW +: CW];
    end

    always_ff @(posedge i_clk) begin
        if (w_en.s1) begin
            r_min1 <= in_min;
            r_max1 <= in_max;
            r_pos1 <= in_pos;
        end
        if (w_en.s2) begin
            r_min2 <= r_min1;
            r_max2 <= r_max1;
            r_pos2 <= r_pos1;
        end
        if (w_en.s3) begin
            r_pos3 <= r_pos2;
        end
        if (w_en.s4) begin
            r_pos4 <= r_pos3;
        end
    end

    qat_matrix u_matrix (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_quat (i_s_tdata[QUAT_W-1:0]),
        .o_m    (w_m)
    );

    for (genvar j = 0; j < AXES; j++) begin : g_axis
        for (genvar k = 0; k < AXES; k++) begin : g_col
            qat_term u_term_min (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_m    (w_m[j*AXES + k]),
                .i_c    (r_min2[k]),
                .o_term (w_ta[j][k])
            );
            qat_term u_term_max (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_m    (w_m[j*AXES + k]),
                .i_c    (r_max2[k]),
                .o_term (w_tb[j][k])
            );
        end

        qat_bound u_bound (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_pos (r_pos4[j]),
            .i_a   (w_ta[j]),
            .i_b   (w_tb[j]),
            .o_min (w_wmin[j]),
            .o_max (w_wmax[j]),
            .o_ovf (w_ovf[j])
        );

        assign o_m_tdata[j*CW +: CW]        = w_wmin[j];
        assign o_m_tdata[(AXES+j)*CW +: CW] = w_wmax[j];
    end

    assign o_m_tuser = |w_ovf;

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_wmin[0] <= w_wmax[0]) && (w_wmin[1] <= w_wmax[1])
                       && (w_wmin[2] <= w_wmax[2]))
        else $error("world min above world max");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_v) && !i_m_tready |-> !o_s_tready)
        else $error("input taken while pipeline full and stalled");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2] && !w_en.s4 |=> r_v[2])
        else $error("stalled stage lost its beat");

endmodule
